// ===== rtl/pa2f_pkg.sv =====
package pa2f_pkg;

    localparam int unsigned PACKETS_PER_FRAME = 128;
    localparam int unsigned BYTES_PER_PACKET  = 8192;

    localparam logic [8:0] PPF_LIMIT = 9'(PACKETS_PER_FRAME);
    localparam logic [7:0] LAST_IDX  = 8'(PACKETS_PER_FRAME - 1);
    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_PLACE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_DROP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STEP_CLOSE_OLD = 2'd0,
        STEP_PLACE     = 2'd1,
        STEP_CLOSE_NEW = 2'd2
    } t_step;

    typedef struct packed {
        logic [63:0] packet_pulse;
        logic [63:0] packet_frame_number;
        logic [31:0] packet_debug_word;
        logic [7:0]  packet_index;
    } t_in_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [63:0] frame_pulse;
        logic [63:0] frame_number_out;
        logic [31:0] frame_debug_out;
        logic [7:0]  module_out;
        logic [7:0]  packets_received;
        logic [19:0] write_offset;
        logic        start_of_frame;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic        drop;
        logic        close_first;
        logic        close_last;
        logic        start;
        logic [63:0] old_pulse;
        logic [63:0] old_fnum;
        logic [31:0] old_debug;
        logic [7:0]  old_count;
        logic [63:0] pulse;
        logic [63:0] fnum;
        logic [31:0] debug;
        logic [7:0]  count;
        logic [19:0] offset;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

endpackage

// ===== rtl/pa2f_front.sv =====
module pa2f_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  pa2f_pkg::t_in_item i_item,
    output pa2f_pkg::t_cmd     o_cmd
);

    logic        r_open;
    logic [7:0]  r_count;
    logic [63:0] r_pulse;
    logic [63:0] r_fnum;
    logic [31:0] r_debug;

    logic        bad;
    logic        differs;
    logic        opening;
    logic        is_last;
    logic [7:0]  base;
    logic [7:0]  cnt;

    always_comb begin
        bad     = {1'b0, i_item.packet_index} >= pa2f_pkg::PPF_LIMIT;
        differs = r_open && (r_pulse != i_item.packet_pulse);
        opening = !r_open || differs;
        is_last = i_item.packet_index == pa2f_pkg::LAST_IDX;
        base    = opening ? 8'd0 : r_count;
        cnt     = (base == pa2f_pkg::COUNT_MAX) ? base : base + 8'd1;

        o_cmd.drop        = bad;
        o_cmd.close_first = !bad && differs;
        o_cmd.close_last  = !bad && is_last;
        o_cmd.start       = !bad && opening;
        o_cmd.old_pulse   = r_pulse;
        o_cmd.old_fnum    = r_fnum;
        o_cmd.old_debug   = r_debug;
        o_cmd.old_count   = r_count;
        if (bad || opening) begin
            o_cmd.pulse = i_item.packet_pulse;
            o_cmd.fnum  = i_item.packet_frame_number;
            o_cmd.debug = i_item.packet_debug_word;
        end else begin
            o_cmd.pulse = r_pulse;
            o_cmd.fnum  = r_fnum;
            o_cmd.debug = r_debug;
        end
        o_cmd.count  = bad ? r_count : cnt;
        o_cmd.offset = bad ? 20'd0
                     : 20'(32'(i_item.packet_index) * pa2f_pkg::BYTES_PER_PACKET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_count <= 8'd0;
        end else if (i_accept && !bad) begin
            r_open  <= !is_last;
            r_count <= is_last ? 8'd0 : cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !bad && opening) begin
            r_pulse <= i_item.packet_pulse;
            r_fnum  <= i_item.packet_frame_number;
            r_debug <= i_item.packet_debug_word;
        end
    end

endmodule

// ===== rtl/pa2f_fifo.sv =====
module pa2f_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pa2f_pkg::t_cmd        i_cmd,
    input  logic                  i_pop,
    output logic                  o_full,
    output pa2f_pkg::t_queue_head o_head
);

    pa2f_pkg::t_cmd r_mem [pa2f_pkg::QUEUE_DEPTH];

    logic [pa2f_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [pa2f_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [pa2f_pkg::QUEUE_AW:0]   r_fill;

    always_comb begin
        o_full       = r_fill == (pa2f_pkg::QUEUE_AW + 1)'(pa2f_pkg::QUEUE_DEPTH);
        o_head.valid = r_fill != '0;
        o_head.cmd   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/pa2f_back.sv =====
module pa2f_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pa2f_pkg::t_queue_head i_head,
    input  logic [7:0]            i_module_number,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pa2f_pkg::t_out_item   o_out_item
);

    pa2f_pkg::t_step     r_step;
    pa2f_pkg::t_step     n_step;
    pa2f_pkg::t_step     eff;
    pa2f_pkg::t_out_item res;
    logic                r_out_valid;
    pa2f_pkg::t_out_item r_out_item;
    logic                load;

    always_comb begin
        if (r_step == pa2f_pkg::STEP_CLOSE_OLD && !i_head.cmd.close_first) begin
            eff = pa2f_pkg::STEP_PLACE;
        end else begin
            eff = r_step;
        end

        res.module_out     = i_module_number;
        res.write_offset   = 20'd0;
        res.start_of_frame = 1'b0;
        res.frame_pulse    = i_head.cmd.pulse;
        res.frame_number_out = i_head.cmd.fnum;
        res.frame_debug_out  = i_head.cmd.debug;
        res.packets_received = i_head.cmd.count;
        res.result_kind    = pa2f_pkg::KIND_PLACE;
        res.last_result    = 1'b0;
        n_step             = r_step;

        unique case (eff)
            pa2f_pkg::STEP_CLOSE_OLD: begin
                res.result_kind      = pa2f_pkg::KIND_DONE;
                res.frame_pulse      = i_head.cmd.old_pulse;
                res.frame_number_out = i_head.cmd.old_fnum;
                res.frame_debug_out  = i_head.cmd.old_debug;
                res.packets_received = i_head.cmd.old_count;
                n_step               = pa2f_pkg::STEP_PLACE;
            end
            pa2f_pkg::STEP_PLACE: begin
                if (i_head.cmd.drop) begin
                    res.result_kind = pa2f_pkg::KIND_DROP;
                    res.last_result = 1'b1;
                end else begin
                    res.result_kind    = pa2f_pkg::KIND_PLACE;
                    res.write_offset   = i_head.cmd.offset;
                    res.start_of_frame = i_head.cmd.start;
                    res.last_result    = !i_head.cmd.close_last;
                end
                n_step = pa2f_pkg::STEP_CLOSE_NEW;
            end
            pa2f_pkg::STEP_CLOSE_NEW: begin
                res.result_kind = pa2f_pkg::KIND_DONE;
                res.last_result = 1'b1;
            end
            default: begin
                res.last_result = 1'b1;
            end
        endcase

        load  = i_head.valid && (!r_out_valid || i_out_ready);
        o_pop = load && res.last_result;
        if (!load) begin
            n_step = r_step;
        end else if (res.last_result) begin
            n_step = pa2f_pkg::STEP_CLOSE_OLD;
        end

        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= pa2f_pkg::STEP_CLOSE_OLD;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= res;
        end
    end

endmodule

// ===== rtl/packet_to_frame_assembler_core.sv =====
// Packet-to-frame assembler. Each input item is one packet header; the block
// tracks the frame being assembled and emits one to three result items per
// input item: an optional completion of a frame closed by a new pulse, the
// placement (or a drop for a bad packet index), and an optional completion
// when the frame's final packet arrives. The last result of an input item
// carries last_result.
// The input channel takes one item per cycle while the internal command
// queue (four entries) has room. The output register delivers one result
// per cycle while the receiver is ready, so an input item occupies it for
// one to three results. An accepted item is written into the command queue,
// and its results are then registered in the output register.
// When the receiver stalls, the output register holds its item, the queue
// fills, and input ready drops once the queue is full.
// The configuration channel is always ready; module_number is copied to
// every result and should be written only while the block is idle.
// Reset clears the open frame, the packet count, the queue and the output
// valid; module_number resets to zero.
module packet_to_frame_assembler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pa2f_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pa2f_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    logic                  module_set;
    logic [7:0]            r_module;
    logic                  accept;
    logic                  q_full;
    logic                  q_pop;
    pa2f_pkg::t_cmd        cmd;
    pa2f_pkg::t_queue_head head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign accept      = i_in_valid && !q_full;
    assign module_set  = r_module != 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module <= 8'd0;
        end else if (i_cfg_valid) begin
            r_module <= i_cfg_data;
        end
    end

    pa2f_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_cmd   (cmd)
    );

    pa2f_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_cmd  (cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_head (head)
    );

    pa2f_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_module_number(r_module),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item)
    );

`ifndef ASSERT_OFF
    a_done_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == pa2f_pkg::KIND_DONE)
        |-> (o_out_item.packets_received != 8'd0))
        else $error("completed frame reports no packets");

    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == pa2f_pkg::KIND_DROP)
        |-> (o_out_item.last_result && !o_out_item.start_of_frame
             && o_out_item.write_offset == 20'd0))
        else $error("dropped item result malformed");

    a_start_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.start_of_frame)
        |-> (o_out_item.result_kind == pa2f_pkg::KIND_PLACE
             && o_out_item.packets_received == 8'd1))
        else $error("start of frame not on first placement");

    a_module_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !module_set) |-> (o_out_item.module_out == 8'd0))
        else $error("module identifier not copied from register");
`endif

endmodule

// ===== tb/packet_to_frame_assembler_core_tb.sv =====
module packet_to_frame_assembler_core_tb;

    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int PHASE_ITEMS      = 20;
    localparam int SETTLE_CYCLES    = 8;
    localparam logic [63:0] ONES64  = '1;
    localparam logic [31:0] ONES32  = '1;
    localparam logic [63:0] ALT_A64 = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] ALT_5_64 = 64'h5555_5555_5555_5555;

    typedef struct {
        pa2f_pkg::t_in_item  item;
        bit                  typed;
        pa2f_pkg::t_out_item want;
    } t_directed_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    pa2f_pkg::t_in_item  i_in_item = '0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [7:0]          i_cfg_data = 8'd0;
    logic                o_in_ready;
    logic                o_out_valid;
    pa2f_pkg::t_out_item o_out_item;
    logic                o_cfg_ready;

    packet_to_frame_assembler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the frame being assembled.
    logic        frame_open = 1'b0;
    logic [63:0] open_pulse = '0;
    logic [63:0] open_frame_number = '0;
    logic [31:0] open_debug = '0;
    logic [7:0]  placed_count = '0;
    logic [7:0]  module_number = '0;

    pa2f_pkg::t_out_item awaited_results[$];
    pa2f_pkg::t_out_item predicted[3];
    int        predicted_count;
    int        mismatch_count = 0;
    int        quiet_cycles = 0;

    bit                  use_typed = 1'b0;
    pa2f_pkg::t_out_item typed_result = '0;

    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        hold_requests = 0;
    int        hold_granted = 0;
    int        hold_left = 0;
    logic [63:0] recent_pulse = '0;

    t_directed_row directed_rows[15];

    function automatic pa2f_pkg::t_out_item close_frame();
        pa2f_pkg::t_out_item done;
        done = '{pa2f_pkg::KIND_DONE, open_pulse, open_frame_number, open_debug,
                 module_number, placed_count, 20'd0, 1'b0, 1'b0};
        frame_open = 1'b0;
        placed_count = '0;
        return done;
    endfunction

    function automatic void assemble_packet(input pa2f_pkg::t_in_item pkt,
                                            output pa2f_pkg::t_out_item res[3],
                                            output int count);
        logic start;
        start = 1'b0;
        count = 0;
        if (32'(pkt.packet_index) >= pa2f_pkg::PACKETS_PER_FRAME) begin
            res[0] = '{pa2f_pkg::KIND_DROP, pkt.packet_pulse, pkt.packet_frame_number,
                       pkt.packet_debug_word, module_number, placed_count, 20'd0, 1'b0,
                       1'b1};
            count = 1;
            return;
        end
        if (frame_open && open_pulse != pkt.packet_pulse) begin
            res[count] = close_frame();
            count++;
        end
        if (!frame_open) begin
            frame_open = 1'b1;
            open_pulse = pkt.packet_pulse;
            open_frame_number = pkt.packet_frame_number;
            open_debug = pkt.packet_debug_word;
            placed_count = '0;
            start = 1'b1;
        end
        if (placed_count != 8'd255) placed_count++;
        res[count] = '{pa2f_pkg::KIND_PLACE, open_pulse, open_frame_number, open_debug,
                       module_number, placed_count,
                       20'(32'(pkt.packet_index) * pa2f_pkg::BYTES_PER_PACKET), start,
                       1'b0};
        count++;
        if (32'(pkt.packet_index) == pa2f_pkg::PACKETS_PER_FRAME - 1) begin
            res[count] = close_frame();
            count++;
        end
        res[count - 1].last_result = 1'b1;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input pa2f_pkg::t_out_item want,
                                input pa2f_pkg::t_out_item got);
        report_field("result_kind", want.result_kind, got.result_kind);
        report_field("frame_pulse", want.frame_pulse, got.frame_pulse);
        report_field("frame_number_out", want.frame_number_out, got.frame_number_out);
        report_field("frame_debug_out", want.frame_debug_out, got.frame_debug_out);
        report_field("module_out", want.module_out, got.module_out);
        report_field("packets_received", want.packets_received, got.packets_received);
        report_field("write_offset", want.write_offset, got.write_offset);
        report_field("start_of_frame", want.start_of_frame, got.start_of_frame);
        report_field("last_result", want.last_result, got.last_result);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) module_number = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                assemble_packet(i_in_item, predicted, predicted_count);
                if (use_typed) begin
                    awaited_results.push_back(typed_result);
                end else begin
                    for (int k = 0; k < predicted_count; k++)
                        awaited_results.push_back(predicted[k]);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: expected no item, actual %h", $time, o_out_item);
                    mismatch_count++;
                end else begin
                    check_result(awaited_results.pop_front(), o_out_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A long hold-off lets the block fill up and push back on its input.
    always @(negedge i_clk) begin
        if (hold_requests != hold_granted) begin
            hold_granted <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    task automatic send_packet(input pa2f_pkg::t_in_item pkt);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= pkt;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_module_number(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly short frames of one pulse; some end on the final packet, some carry a bad index.
    task automatic send_random_frame(inout int sent);
        pa2f_pkg::t_in_item pkt;
        logic [63:0]        pulse;
        int                 length;
        int                 roll;
        case ($urandom_range(0, 9))
            0: pulse = '0;
            1: pulse = ONES64;
            2: pulse = recent_pulse;
            default: pulse = {$urandom, $urandom};
        endcase
        recent_pulse = pulse;
        length = $urandom_range(1, 6);
        for (int i = 0; i < length; i++) begin
            roll = $urandom_range(0, 99);
            pkt.packet_pulse = pulse;
            pkt.packet_frame_number = {$urandom, $urandom};
            pkt.packet_debug_word = $urandom;
            if (roll < 10) begin
                pkt.packet_index = 8'($urandom_range(128, 255));
            end else if (i == length - 1 && roll < 50) begin
                pkt.packet_index = 8'(pa2f_pkg::PACKETS_PER_FRAME - 1);
            end else begin
                pkt.packet_index = 8'($urandom_range(0, pa2f_pkg::PACKETS_PER_FRAME - 1));
            end
            send_packet(pkt);
            sent++;
        end
    endtask

    initial begin
        logic [7:0] cfg_values[4];
        int         idle_pcts[4];
        int         stall_pcts[4];
        int         sent;

        directed_rows = '{
            '{'{64'd0, 64'd0, 32'd0, 8'd0}, 1'b1,
              '{pa2f_pkg::KIND_PLACE, 64'd0, 64'd0, 32'd0, 8'd0, 8'd1, 20'd0, 1'b1,
                1'b1}},
            '{'{64'd0, ONES64, ONES32, 8'd255}, 1'b1,
              '{pa2f_pkg::KIND_DROP, 64'd0, ONES64, ONES32, 8'd0, 8'd1, 20'd0, 1'b0,
                1'b1}},
            '{'{64'd0, 64'd9, 32'd9, 8'd128}, 1'b1,
              '{pa2f_pkg::KIND_DROP, 64'd0, 64'd9, 32'd9, 8'd0, 8'd1, 20'd0, 1'b0,
                1'b1}},
            '{'{64'd0, 64'd3, 32'd3, 8'd1}, 1'b0, '0},
            '{'{64'd0, 64'd3, 32'd3, 8'd1}, 1'b0, '0},
            '{'{64'd0, 64'd4, 32'd4, 8'd127}, 1'b0, '0},
            '{'{ONES64, ONES64, ONES32, 8'd127}, 1'b0, '0},
            '{'{64'd5, 64'd10, 32'hA5A5_A5A5, 8'd0}, 1'b0, '0},
            '{'{64'd6, 64'd11, 32'h5A5A_5A5A, 8'd3}, 1'b0, '0},
            '{'{64'd7, 64'd12, 32'd1, 8'd127}, 1'b0, '0},
            '{'{ALT_A64, ALT_5_64, 32'hAAAA_AAAA, 8'h55}, 1'b0, '0},
            '{'{ALT_5_64, ALT_A64, 32'h5555_5555, 8'h2A}, 1'b0, '0},
            '{'{ALT_5_64, 64'd0, 32'd0, 8'd126}, 1'b0, '0},
            '{'{ALT_5_64, 64'd0, 32'd0, 8'hAA}, 1'b0, '0},
            '{'{64'd8, 64'd1, 32'd1, 8'd0}, 1'b0, '0}
        };
        cfg_values = '{8'hFF, 8'($urandom), 8'h00, 8'h80};
        idle_pcts = '{0, 61, 0, 23};
        stall_pcts = '{0, 0, 61, 23};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            use_typed = directed_rows[r].typed;
            typed_result = directed_rows[r].want;
            send_packet(directed_rows[r].item);
        end
        use_typed = 1'b0;

        for (int phase = 0; phase < 4; phase++) begin
            wait_for_idle();
            write_module_number(cfg_values[phase]);
            sender_idle_pct = idle_pcts[phase];
            receiver_stall_pct = stall_pcts[phase];
            if (phase == 0) hold_requests++;
            sent = 0;
            while (sent < PHASE_ITEMS) send_random_frame(sent);
        end

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pa2f_pkg.sv
rtl/pa2f_front.sv
rtl/pa2f_fifo.sv
rtl/pa2f_back.sv
rtl/packet_to_frame_assembler_core.sv
tb/packet_to_frame_assembler_core_tb.sv
